@@ hw/rtl/dns_response_record_extractor_unit_defines.svh @@
// Assertion macros for the DNS response record extractor.
`ifndef DNS_RESPONSE_RECORD_EXTRACTOR_UNIT_DEFINES_SVH
`define DNS_RESPONSE_RECORD_EXTRACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DRX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DRX_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/drx_pkg.sv @@
package drx_pkg;
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_RCODE     = 3'd1;
   localparam logic [2:0] STATUS_NO_ANSWER = 3'd2;
   localparam logic [2:0] STATUS_LOOP      = 3'd3;
   localparam logic [2:0] STATUS_TRUNC     = 3'd4;
   localparam logic [2:0] STATUS_LIMIT     = 3'd5;
   localparam logic [3:0] HOP_LIMIT_RESET  = 4'd10;
   localparam logic [7:0] POINTER_MASK     = 8'hC0;
   localparam logic [7:0] OFFSET_MASK      = 8'h3F;
   localparam int         HEADER_BYTES     = 12;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  response_code;
      logic [5:0]  record_index;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] time_to_live;
      logic [8:0]  rdata_offset;
      logic [15:0] rdata_length;
      logic [31:0] ipv4_address;
      logic        ipv4_valid;
      logic        last_of_run;
   } result_type;
endpackage

@@ hw/rtl/drx_packet_ram.sv @@
module drx_packet_ram #(
   parameter int DEPTH = 512,
   parameter int AW = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hw/rtl/drx_parser.sv @@
module drx_parser #(
   parameter int AW = 9,
   parameter int LW = 10,
   parameter int MAX_RECORDS = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [LW-1:0]       len,
   input  logic [3:0]          hop_limit,
   output logic [AW-1:0]       rd_addr,
   input  logic [7:0]          rd_data,
   output logic                busy,
   output logic                out_valid,
   output drx_pkg::result_type out_item
);
   // Positions are kept 18 bits wide: wide enough for pos + 65535 + 10 etc.
   localparam int PW = 18;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_READ   = 5'd1;
   localparam logic [4:0] S_HDR    = 5'd2;
   localparam logic [4:0] S_QLOOP  = 5'd3;
   localparam logic [4:0] S_NREQ   = 5'd4;
   localparam logic [4:0] S_NBYTE  = 5'd5;
   localparam logic [4:0] S_NPTR   = 5'd6;
   localparam logic [4:0] S_QDONE  = 5'd7;
   localparam logic [4:0] S_ALOOP  = 5'd8;
   localparam logic [4:0] S_ADONE  = 5'd9;
   localparam logic [4:0] S_FIELDS = 5'd10;
   localparam logic [4:0] S_RDCHK  = 5'd11;
   localparam logic [4:0] S_IP     = 5'd12;
   localparam logic [4:0] S_EMIT   = 5'd13;
   localparam logic [4:0] S_FINAL  = 5'd14;

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic [PW-1:0] pos_ff, pos_in, p_ff, p_in, resume_ff, resume_in;
   logic [PW-1:0] base_ff, base_in;
   logic [PW-1:0] len_ff, len_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [4:0]    hops_ff, hops_in;
   logic          jumped_ff, jumped_in, isptr_ff, isptr_in;
   logic [7:0]    first_ff, first_in;
   logic [15:0]   qd_ff, qd_in, an_ff, an_in, idx_ff, idx_in;
   logic [3:0]    rcode_ff, rcode_in;
   logic [2:0]    st_ff, st_in;
   logic [79:0]   sh_ff, sh_in;
   logic [79:0]   save_ff, save_in;
   logic [31:0]   ip_ff, ip_in;
   logic [5:0]    n_ff, n_in;
   logic          ov_ff, ov_in;
   drx_pkg::result_type oi_ff, oi_in;
   logic [PW-1:0] lenx, rdlen;
   logic [PW-1:0] radr;

   assign lenx  = len_ff;
   assign rdlen = PW'(sh_ff[15:0]);
   assign rd_addr  = radr[AW-1:0];
   assign busy     = state_ff != S_IDLE;
   assign out_valid = ov_ff;
   assign out_item  = oi_ff;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; pos_in = pos_ff; p_in = p_ff;
      resume_in = resume_ff; base_in = base_ff; cnt_in = cnt_ff; len_in = len_ff;
      hops_in = hops_ff; jumped_in = jumped_ff; isptr_in = isptr_ff;
      first_in = first_ff; qd_in = qd_ff; an_in = an_ff; idx_in = idx_ff;
      rcode_in = rcode_ff; st_in = st_ff; sh_in = sh_ff; ip_in = ip_ff;
      n_in = n_ff; ov_in = 1'b0; oi_in = oi_ff;
      radr = base_ff + PW'(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               len_in = PW'(len);
               rcode_in = '0; n_in = '0; idx_in = '0; st_in = drx_pkg::STATUS_OK;
               if (PW'(len) < PW'(drx_pkg::HEADER_BYTES)) begin
                  st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
               end else begin
                  radr = PW'(3);
                  base_in = '0; cnt_in = 4'd3; ret_in = S_HDR; state_in = S_READ;
               end
            end
         end
         // fetch bytes from base+cnt upward, shifting each into sh
         S_READ: begin
            sh_in = {sh_ff[71:0], rd_data};
            if (cnt_ff == 4'd3 && ret_ff == S_HDR) begin
               rcode_in = rd_data[3:0];
            end
            if ((ret_ff == S_HDR && cnt_ff == 4'd7) || (ret_ff == S_FIELDS && cnt_ff == 4'd9)
                || (ret_ff == S_IP && cnt_ff == 4'd3)) begin
               state_in = ret_ff;
            end else begin
               cnt_in = cnt_ff + 4'd1;
               radr = base_ff + PW'(cnt_ff + 4'd1);
            end
         end
         S_HDR: begin
            qd_in = sh_ff[31:16]; an_in = sh_ff[15:0];
            if (rcode_ff != 4'd0) begin
               st_in = drx_pkg::STATUS_RCODE; state_in = S_FINAL;
            end else if (sh_ff[15:0] == 16'd0) begin
               st_in = drx_pkg::STATUS_NO_ANSWER; state_in = S_FINAL;
            end else begin
               pos_in = PW'(drx_pkg::HEADER_BYTES); idx_in = '0; state_in = S_QLOOP;
            end
         end
         S_QLOOP: begin
            if (idx_ff == qd_ff) begin
               idx_in = '0; state_in = S_ALOOP;
            end else begin
               ret_in = S_QDONE; p_in = pos_ff; hops_in = '0; jumped_in = 1'b0;
               state_in = S_NREQ;
            end
         end
         S_NREQ: begin
            radr = p_ff; isptr_in = 1'b0;
            if (p_ff >= lenx) begin
               st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
            end else begin
               state_in = S_NBYTE;
            end
         end
         S_NBYTE: begin
            if (isptr_ff) begin
               p_in = (PW'(first_ff & drx_pkg::OFFSET_MASK) << 8) | PW'(rd_data);
               if (!jumped_ff) begin
                  resume_in = p_ff + PW'(1); jumped_in = 1'b1;
               end
               hops_in = hops_ff + 5'd1;
               if (hops_ff + 5'd1 > {1'b0, hop_limit}) begin
                  st_in = drx_pkg::STATUS_LOOP; state_in = S_FINAL;
               end else begin
                  state_in = S_NREQ;
               end
            end else if (rd_data == 8'd0) begin
               pos_in = jumped_ff ? resume_ff : p_ff + PW'(1);
               state_in = ret_ff;
            end else if ((rd_data & drx_pkg::POINTER_MASK) == drx_pkg::POINTER_MASK) begin
               state_in = S_NPTR; first_in = rd_data;
            end else begin
               p_in = p_ff + PW'(1) + PW'(rd_data);
               if (p_ff + PW'(1) + PW'(rd_data) > lenx) begin
                  st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
               end else begin
                  state_in = S_NREQ;
               end
            end
         end
         S_NPTR: begin
            radr = p_ff + PW'(1); isptr_in = 1'b1; p_in = p_ff + PW'(1);
            if (p_ff + PW'(1) >= lenx) begin
               st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
            end else begin
               state_in = S_NBYTE;
            end
         end
         S_QDONE: begin
            pos_in = pos_ff + PW'(4); idx_in = idx_ff + 16'd1; state_in = S_QLOOP;
         end
         S_ALOOP: begin
            if (idx_ff == an_ff) begin
               state_in = S_FINAL;
            end else if (idx_ff >= 16'(MAX_RECORDS)) begin
               st_in = drx_pkg::STATUS_LIMIT; state_in = S_FINAL;
            end else begin
               ret_in = S_ADONE; p_in = pos_ff; hops_in = '0; jumped_in = 1'b0;
               state_in = S_NREQ;
            end
         end
         S_ADONE: begin
            if (pos_ff + PW'(10) > lenx) begin
               st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
            end else begin
               radr = pos_ff;
               base_in = pos_ff; cnt_in = '0; ret_in = S_FIELDS; state_in = S_READ;
            end
         end
         S_FIELDS: begin
            ip_in = '0;
            state_in = S_RDCHK;
         end
         S_RDCHK: begin
            if (pos_ff + PW'(10) + rdlen > lenx) begin
               st_in = drx_pkg::STATUS_TRUNC; state_in = S_FINAL;
            end else if (sh_ff[79:64] == 16'd1 && sh_ff[15:0] == 16'd4) begin
               radr = pos_ff + PW'(10);
               base_in = pos_ff + PW'(10); cnt_in = '0; ret_in = S_IP;
               state_in = S_READ;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_IP: begin
            // take the address, then restore the record fields it shifted out
            ip_in = sh_ff[31:0];
            sh_in = save_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            ov_in = 1'b1;
            oi_in = '0;
            oi_in.response_code = rcode_ff;
            oi_in.record_index  = idx_ff[5:0];
            oi_in.record_type   = sh_ff[79:64];
            oi_in.record_class  = sh_ff[63:48];
            oi_in.time_to_live  = sh_ff[47:16];
            oi_in.rdata_offset  = 9'(pos_ff + PW'(10));
            oi_in.rdata_length  = sh_ff[15:0];
            oi_in.ipv4_address  = ip_ff;
            oi_in.ipv4_valid    = (sh_ff[79:64] == 16'd1 && sh_ff[15:0] == 16'd4);
            n_in = n_ff + 6'd1;
            pos_in = pos_ff + PW'(10) + rdlen;
            idx_in = idx_ff + 16'd1;
            state_in = S_ALOOP;
         end
         S_FINAL: begin
            ov_in = 1'b1;
            oi_in = '0;
            oi_in.status = st_ff;
            oi_in.response_code = rcode_ff;
            oi_in.record_index = n_ff;
            oi_in.last_of_run = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the record fields while the address bytes go through sh
   always_comb begin
      save_in = save_ff;
      if (state_ff == S_RDCHK) save_in = sh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in;
      end
      ret_ff <= ret_in; pos_ff <= pos_in; p_ff <= p_in; resume_ff <= resume_in;
      base_ff <= base_in; cnt_ff <= cnt_in; hops_ff <= hops_in; len_ff <= len_in;
      jumped_ff <= jumped_in; isptr_ff <= isptr_in; first_ff <= first_in;
      qd_ff <= qd_in; an_ff <= an_in; idx_ff <= idx_in; rcode_ff <= rcode_in;
      st_ff <= st_in; ip_ff <= ip_in; n_ff <= n_in; oi_ff <= oi_in;
      save_ff <= save_in;
      sh_ff <= sh_in;
   end
endmodule

@@ hw/rtl/dns_response_record_extractor_unit.sv @@
// DNS response record extractor. Packet bytes are taken one per cycle, while
// busy is low, into a packet RAM; the byte with end_of_packet set closes the
// packet and starts a parse walk. The walk reads the header, then the name of
// each question, then the name, fixed fields and, for an A record, the address
// of each answer record, following compression pointers. busy stays high from
// the cycle after the closing byte until the status word appears. Each answer
// record and the closing status word appear on the rsp_ ports for one cycle
// with rsp_valid; the receiver cannot stall, so take every strobe.
`include "dns_response_record_extractor_unit_defines.svh"
module dns_response_record_extractor_unit #(
   parameter int PACKET_BYTES = 512,
   parameter int MAX_RECORDS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_end_of_packet,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_response_code,
   output logic [5:0]  rsp_record_index,
   output logic [15:0] rsp_record_type,
   output logic [15:0] rsp_record_class,
   output logic [31:0] rsp_time_to_live,
   output logic [8:0]  rsp_rdata_offset,
   output logic [15:0] rsp_rdata_length,
   output logic [31:0] rsp_ipv4_address,
   output logic        rsp_ipv4_valid,
   output logic        rsp_last_of_run
);
   localparam int AW = $clog2(PACKET_BYTES);
   localparam int LW = $clog2(PACKET_BYTES + 1);

   logic [3:0]    hop_ff;
   logic [LW-1:0] fill_ff;
   logic          take, go, pbusy;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          go_ff;
   logic          rec_word, rec_ok;
   drx_pkg::result_type item;

   assign take = start && !busy;
   assign go   = take && req_end_of_packet;
   assign busy = pbusy || go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff <= drx_pkg::HOP_LIMIT_RESET; fill_ff <= '0; go_ff <= 1'b0;
      end else begin
         if (csr_write_enable) hop_ff <= csr_write_data;
         go_ff <= go;
         if (go_ff) fill_ff <= '0;
         else if (take && fill_ff < LW'(PACKET_BYTES)) fill_ff <= fill_ff + LW'(1);
      end
   end

   drx_packet_ram #(.DEPTH(PACKET_BYTES), .AW(AW)) u_ram (
      .clock, .wr_en(take && fill_ff < LW'(PACKET_BYTES)),
      .wr_addr(fill_ff[AW-1:0]), .wr_data(req_packet_byte),
      .rd_addr, .rd_data
   );

   drx_parser #(.AW(AW), .LW(LW), .MAX_RECORDS(MAX_RECORDS)) u_parser (
      .clock, .reset, .go(go_ff), .len(fill_ff), .hop_limit(hop_ff),
      .rd_addr, .rd_data, .busy(pbusy), .out_valid(rsp_valid), .out_item(item)
   );

   assign rsp_status        = item.status;
   assign rsp_response_code = item.response_code;
   assign rsp_record_index  = item.record_index;
   assign rsp_record_type   = item.record_type;
   assign rsp_record_class  = item.record_class;
   assign rsp_time_to_live  = item.time_to_live;
   assign rsp_rdata_offset  = item.rdata_offset;
   assign rsp_rdata_length  = item.rdata_length;
   assign rsp_ipv4_address  = item.ipv4_address;
   assign rsp_ipv4_valid    = item.ipv4_valid;
   assign rsp_last_of_run   = item.last_of_run;

   assign rec_word = rsp_valid && !rsp_last_of_run;
   assign rec_ok   = rsp_status == drx_pkg::STATUS_OK;

   `DRX_ASSERT_NEXT(a_go_busy, clock, reset, go, busy, "busy missing after last word")
   `DRX_ASSERT_IMPL(a_last_ok, clock, reset, rec_word, rec_ok, "record word with error status")
   `DRX_ASSERT_IMPL(a_ipv4, clock, reset, rsp_valid && rsp_ipv4_valid, rsp_rdata_length == 16'd4, "ipv4 flag on bad length")
endmodule

@@ dv/dns_response_record_extractor_unit_test.sv @@
`timescale 1ns / 1ps

localparam int PKT_BYTES = 512;
localparam int RECORD_CAP = 63;

typedef logic [7:0] octet_q[$];

class dns_record_scoreboard;
   logic [7:0] packet_ram[PKT_BYTES];
   int unsigned fill;
   logic [3:0] hop_limit;
   drx_pkg::result_type pending[$];
   int errors;
   int words_seen;

   function new();
      fill = 0;
      hop_limit = drx_pkg::HOP_LIMIT_RESET;
      errors = 0;
      words_seen = 0;
   endfunction

   function int unsigned rd16(int unsigned p);
      return {packet_ram[p], packet_ram[p + 1]};
   endfunction

   function logic [31:0] rd32(int unsigned p);
      return {16'(rd16(p)), 16'(rd16(p + 2))};
   endfunction

   // walk one name, following pointers; leaves pos after the name
   function logic [2:0] walk_name(int unsigned len, inout int unsigned pos);
      int unsigned p, resume, hops;
      logic [7:0] b;
      bit jumped;
      p = pos;
      resume = 0;
      hops = 0;
      jumped = 0;
      forever begin
         if (p >= len) return drx_pkg::STATUS_TRUNC;
         b = packet_ram[p];
         if (b == 8'd0) begin
            p++;
            break;
         end
         if ((b & drx_pkg::POINTER_MASK) == drx_pkg::POINTER_MASK) begin
            if (p + 1 >= len) return drx_pkg::STATUS_TRUNC;
            if (!jumped) begin
               resume = p + 2;
               jumped = 1;
            end
            hops++;
            if (hops > hop_limit) return drx_pkg::STATUS_LOOP;
            p = {b & drx_pkg::OFFSET_MASK, packet_ram[p + 1]};
            continue;
         end
         p += 1 + b;
         if (p > len) return drx_pkg::STATUS_TRUNC;
      end
      pos = jumped ? resume : p;
      return drx_pkg::STATUS_OK;
   endfunction

   function void push_word(logic [2:0] st, logic [3:0] rc, int unsigned idx,
                           int unsigned rtype, int unsigned rclass, logic [31:0] ttl,
                           int unsigned rdoff, int unsigned rdlen, logic [31:0] ip,
                           logic ipv, logic last);
      drx_pkg::result_type r;
      r.status = st;
      r.response_code = rc;
      r.record_index = 6'(idx);
      r.record_type = 16'(rtype);
      r.record_class = 16'(rclass);
      r.time_to_live = ttl;
      r.rdata_offset = 9'(rdoff);
      r.rdata_length = 16'(rdlen);
      r.ipv4_address = ip;
      r.ipv4_valid = ipv;
      r.last_of_run = last;
      pending.push_back(r);
   endfunction

   function void parse_packet();
      int unsigned len, qd, an, pos, i, n, rtype, rclass, rdlen, rdoff;
      logic [3:0] rc;
      logic [2:0] st;
      logic [31:0] ttl, ip;
      logic ipv;
      len = fill;
      n = 0;
      if (len < drx_pkg::HEADER_BYTES) begin
         push_word(drx_pkg::STATUS_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
         return;
      end
      rc = packet_ram[3][3:0];
      if (rc != 0) begin
         push_word(drx_pkg::STATUS_RCODE, rc, 0, 0, 0, 0, 0, 0, 0, 0, 1);
         return;
      end
      qd = rd16(4);
      an = rd16(6);
      if (an == 0) begin
         push_word(drx_pkg::STATUS_NO_ANSWER, rc, 0, 0, 0, 0, 0, 0, 0, 0, 1);
         return;
      end
      pos = drx_pkg::HEADER_BYTES;
      for (i = 0; i < qd; i++) begin
         st = walk_name(len, pos);
         if (st != drx_pkg::STATUS_OK) begin
            push_word(st, rc, 0, 0, 0, 0, 0, 0, 0, 0, 1);
            return;
         end
         pos += 4;
      end
      st = drx_pkg::STATUS_OK;
      for (i = 0; i < an; i++) begin
         if (i >= RECORD_CAP) begin
            st = drx_pkg::STATUS_LIMIT;
            break;
         end
         st = walk_name(len, pos);
         if (st != drx_pkg::STATUS_OK) break;
         if (pos + 10 > len) begin
            st = drx_pkg::STATUS_TRUNC;
            break;
         end
         rtype = rd16(pos);
         rclass = rd16(pos + 2);
         ttl = rd32(pos + 4);
         rdlen = rd16(pos + 8);
         rdoff = pos + 10;
         if (rdoff + rdlen > len) begin
            st = drx_pkg::STATUS_TRUNC;
            break;
         end
         ip = 0;
         ipv = 0;
         if (rtype == 1 && rdlen == 4) begin
            ip = rd32(rdoff);
            ipv = 1;
         end
         push_word(drx_pkg::STATUS_OK, rc, i, rtype, rclass, ttl, rdoff, rdlen, ip, ipv, 0);
         n++;
         pos = rdoff + rdlen;
      end
      push_word(st, rc, n, 0, 0, 0, 0, 0, 0, 0, 1);
   endfunction

   function void note_word(logic [7:0] data, logic eop);
      if (fill < PKT_BYTES) begin
         packet_ram[fill] = data;
         fill++;
      end
      if (eop) begin
         parse_packet();
         fill = 0;
      end
   endfunction

   function void report(string field, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(drx_pkg::result_type got);
      drx_pkg::result_type e;
      words_seen++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word: expected none, actual %p", $time, got);
         errors++;
         return;
      end
      e = pending.pop_front();
      report("status", e.status, got.status);
      report("response_code", e.response_code, got.response_code);
      report("record_index", e.record_index, got.record_index);
      report("record_type", e.record_type, got.record_type);
      report("record_class", e.record_class, got.record_class);
      report("time_to_live", e.time_to_live, got.time_to_live);
      report("rdata_offset", e.rdata_offset, got.rdata_offset);
      report("rdata_length", e.rdata_length, got.rdata_length);
      report("ipv4_address", e.ipv4_address, got.ipv4_address);
      report("ipv4_valid", e.ipv4_valid, got.ipv4_valid);
      report("last_of_run", e.last_of_run, got.last_of_run);
   endfunction
endclass

module dns_response_record_extractor_unit_test;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [7:0]  req_packet_byte = 0;
   logic        req_end_of_packet = 0;
   logic        csr_write_enable = 0;
   logic [3:0]  csr_write_data = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_response_code;
   logic [5:0]  rsp_record_index;
   logic [15:0] rsp_record_type;
   logic [15:0] rsp_record_class;
   logic [31:0] rsp_time_to_live;
   logic [8:0]  rsp_rdata_offset;
   logic [15:0] rsp_rdata_length;
   logic [31:0] rsp_ipv4_address;
   logic        rsp_ipv4_valid;
   logic        rsp_last_of_run;

   dns_record_scoreboard sb = new();
   int bytes_sent = 0;
   int cycles = 0;
   bit idle_ok = 1;

   dns_response_record_extractor_unit DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 500000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      drx_pkg::result_type r;
      if (!reset && rsp_valid) begin
         r.status = rsp_status;
         r.response_code = rsp_response_code;
         r.record_index = rsp_record_index;
         r.record_type = rsp_record_type;
         r.record_class = rsp_record_class;
         r.time_to_live = rsp_time_to_live;
         r.rdata_offset = rsp_rdata_offset;
         r.rdata_length = rsp_rdata_length;
         r.ipv4_address = rsp_ipv4_address;
         r.ipv4_valid = rsp_ipv4_valid;
         r.last_of_run = rsp_last_of_run;
         sb.check_result(r);
      end
   end

   function automatic void push_name(ref octet_q q);
      int nlab;
      int len;
      nlab = $urandom_range(0, 2);
      repeat (nlab) begin
         len = $urandom_range(1, 6);
         q.push_back(8'(len));
         repeat (len) q.push_back(8'($urandom));
      end
      q.push_back(8'd0);
   endfunction

   // well-formed response; chain makes later answers point at the first
   // answer's name, which itself may be a pointer
   function automatic octet_q build_response(int qd, int an, bit chain);
      octet_q q;
      int first_name;
      int rdlen;
      logic [15:0] rtype;
      first_name = -1;
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
      q.push_back({4'($urandom), 4'h0});
      q.push_back(8'(qd >> 8));
      q.push_back(8'(qd));
      q.push_back(8'(an >> 8));
      q.push_back(8'(an));
      repeat (4) q.push_back(8'($urandom));
      repeat (qd) begin
         push_name(q);
         repeat (4) q.push_back(8'($urandom));
      end
      for (int i = 0; i < an; i++) begin
         if (chain && first_name >= 0) begin
            q.push_back(8'hC0 | 8'(first_name >> 8));
            q.push_back(8'(first_name));
         end else begin
            if (i == 0) first_name = q.size();
            if (qd > 0 && $urandom_range(0, 1)) begin
               q.push_back(8'hC0);
               q.push_back(8'h0C);
            end else
               push_name(q);
         end
         rtype = ($urandom_range(0, 3) != 0) ? 16'd1 : 16'($urandom);
         rdlen = ($urandom_range(0, 2) != 0) ? 4 : $urandom_range(0, 8);
         q.push_back(rtype[15:8]);
         q.push_back(rtype[7:0]);
         repeat (6) q.push_back(8'($urandom));
         q.push_back(8'(rdlen >> 8));
         q.push_back(8'(rdlen));
         repeat (rdlen) q.push_back(8'($urandom));
      end
      return q;
   endfunction

   function automatic octet_q header_only(int qd, int an);
      octet_q q;
      q = build_response(0, 0, 0);
      q[4] = 8'(qd >> 8);
      q[5] = 8'(qd);
      q[6] = 8'(an >> 8);
      q[7] = 8'(an);
      return q;
   endfunction

   task automatic send_packet(octet_q q);
      for (int i = 0; i < q.size(); i++) begin
         if (idle_ok && $urandom_range(0, 3) == 0) begin
            start = 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         start = 1;
         req_packet_byte = q[i];
         req_end_of_packet = (i == q.size() - 1);
         do @(posedge clock); while (busy);
         sb.note_word(req_packet_byte, req_end_of_packet);
         bytes_sent++;
         @(negedge clock);
      end
      start = 0;
      req_end_of_packet = 0;
   endtask

   task automatic write_hop_limit(logic [3:0] value);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 0;
      sb.hop_limit = value;
   endtask

   initial begin
      octet_q q;
      int kind;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: short header, single byte, nonzero rcode, no answers, clean
      q = {};
      repeat (5) q.push_back(8'($urandom));
      send_packet(q);
      send_packet('{8'hFF});
      q = header_only(1, 1);
      q[3][3:0] = 4'hF;
      send_packet(q);
      send_packet(header_only(1, 0));
      send_packet(build_response(1, 2, 0));
      // name pointing at itself
      q = header_only(0, 1);
      q.push_back(8'hC0);
      q.push_back(8'h0C);
      send_packet(q);
      // 0x40..0xBF length byte taken as a plain label
      q = header_only(1, 1);
      q.push_back(8'h81);
      send_packet(q);
      // pointer cut short, then pointer beyond the packet
      q = header_only(1, 1);
      q.push_back(8'hC0);
      send_packet(q);
      q = header_only(1, 1);
      q.push_back(8'hC1);
      q.push_back(8'hFF);
      send_packet(q);
      // answer record cut short at its end
      q = build_response(1, 1, 0);
      q = q[0:q.size() - 3];
      send_packet(q);
      // answer count far larger than the records present
      q = build_response(1, 2, 1);
      q[6] = 8'hFF;
      q[7] = 8'hFF;
      send_packet(q);

      write_hop_limit(4'd0);
      send_packet(build_response(1, 2, 1));
      write_hop_limit(4'd1);
      send_packet(build_response(1, 3, 1));
      write_hop_limit(4'd15);
      q = header_only(0, 1);
      q.push_back(8'hC0);
      q.push_back(8'h0C);
      send_packet(q);

      // random: mostly well-formed responses, some damaged or noise
      while (bytes_sent < 460) begin
         idle_ok = bytes_sent < 400;
         if ($urandom_range(0, 7) == 0) write_hop_limit(4'($urandom));
         q = build_response($urandom_range(0, 1), $urandom_range(1, 3), $urandom_range(0, 1));
         kind = $urandom_range(0, 9);
         case (kind)
            0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            1: q = q[0:$urandom_range(0, q.size() - 1)];
            2: begin
               q = {};
               repeat ($urandom_range(1, 40)) q.push_back(8'($urandom));
            end
            3: q[3][3:0] = 4'($urandom);
            default: ;
         endcase
         send_packet(q);
      end

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

@@ dns_response_record_extractor_unit.f @@
+incdir+hw/rtl
hw/rtl/drx_pkg.sv
hw/rtl/drx_packet_ram.sv
hw/rtl/drx_parser.sv
hw/rtl/dns_response_record_extractor_unit.sv
dv/dns_response_record_extractor_unit_test.sv
